// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the slot priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // operation carried by the opcode field
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_DEL_SCAN,
    ST_DEL_PICK,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/slot_priority_queue.sv =====
// ----------------------------------------------------------------------------
// slot_priority_queue
// Fixed table of slots holding value/priority pairs; insert into the lowest
// free slot, delete-min returns the lowest-priority entry (lowest index wins).
// ----------------------------------------------------------------------------
//
//   channel | handshake              | word fields
//   --------+------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o | opcode_i, item_value_i, item_priority_i
//   out     | out_valid_o/ out_ready_i| status_o, out_value_o, out_slot_o
//
// one word at a time; insert scans the valid flops from slot 0 to the first
// free slot, delete-min checks every slot through the scan that reads the
// slot ram one entry per cycle
// the next input word is taken while a result still waits on the output
// reset empties the table through the valid flops, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module slot_priority_queue #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned PRIO_BITS  = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic        [7:0]  item_priority_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] out_value_o,
  output logic             [2:0]  out_slot_o
);

  localparam int unsigned IdxW     = $clog2(SLOTS);
  localparam int unsigned CntW     = $clog2(SLOTS + 1);
  localparam int unsigned WordW    = PRIO_BITS + VALUE_BITS;
  localparam int unsigned ValExtW  = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int unsigned PrioExtW = (PRIO_BITS > 8) ? PRIO_BITS : 8;
  localparam int unsigned SlotExtW = (IdxW > 3) ? IdxW : 3;

  spq_pkg::state_e state_q, state_d;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [WordW-1:0]      ins_word_q, ins_word_d;
  logic                  stage_q, stage_d;
  logic                  stage_live_q, stage_live_d;
  logic [IdxW-1:0]       stage_idx_q, stage_idx_d;
  logic                  found_q, found_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [PRIO_BITS-1:0]  best_prio_q, best_prio_d;
  logic [VALUE_BITS-1:0] best_val_q, best_val_d;

  spq_pkg::status_e      res_status_q, res_status_d;
  logic signed [31:0]    res_value_q, res_value_d;
  logic [IdxW-1:0]       res_slot_q, res_slot_d;

  logic                  out_valid_q, out_valid_d;
  spq_pkg::status_e      out_status_q, out_status_d;
  logic signed [31:0]    out_value_q, out_value_d;
  logic [2:0]            out_slot_q, out_slot_d;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [IdxW-1:0]       mem_raddr;
  logic [WordW-1:0]      mem_rdata;

  logic [IdxW-1:0]            cur_idx;
  logic signed [ValExtW-1:0]  in_val_ext;
  logic [PrioExtW-1:0]        in_prio_ext;
  logic [PRIO_BITS-1:0]       rd_prio;
  logic [VALUE_BITS-1:0]      rd_val;
  logic signed [ValExtW-1:0]  best_val_ext;
  logic [SlotExtW-1:0]        res_slot_ext;

  assign cur_idx      = cnt_q[IdxW-1:0];
  assign in_val_ext   = ValExtW'(item_value_i);
  assign in_prio_ext  = PrioExtW'(item_priority_i);
  assign rd_prio      = mem_rdata[WordW-1 -: PRIO_BITS];
  assign rd_val       = mem_rdata[VALUE_BITS-1:0];
  assign best_val_ext = ValExtW'(signed'(best_val_q));
  assign res_slot_ext = SlotExtW'(res_slot_q);

  spq_slot_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ins_word_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    ins_word_d   = ins_word_q;
    stage_d      = 1'b0;
    stage_live_d = stage_live_q;
    stage_idx_d  = stage_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_val_d   = best_val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_slot_d   = out_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_idx;
    mem_raddr    = cur_idx;
    in_ready_o   = 1'b0;

    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ins_word_d = {in_prio_ext[PRIO_BITS-1:0], in_val_ext[VALUE_BITS-1:0]};
          cnt_d      = '0;
          found_d    = 1'b0;
          state_d    = (opcode_i == spq_pkg::OP_DELETE) ? spq_pkg::ST_DEL_SCAN
                                                        : spq_pkg::ST_INS_SCAN;
        end
      end

      spq_pkg::ST_INS_SCAN: begin
        if (!valid_q[cur_idx]) begin
          mem_we           = 1'b1;
          valid_d[cur_idx] = 1'b1;
          res_status_d     = spq_pkg::STATUS_DONE;
          res_value_d      = '0;
          res_slot_d       = cur_idx;
          state_d          = spq_pkg::ST_FINISH;
        end else if (cnt_q == CntW'(SLOTS - 1)) begin
          res_status_d = spq_pkg::STATUS_FULL;
          res_value_d  = '0;
          res_slot_d   = '0;
          state_d      = spq_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      spq_pkg::ST_DEL_SCAN: begin
        // issue the read for this slot, judge the one read last cycle
        if (cnt_q != CntW'(SLOTS)) begin
          stage_d      = 1'b1;
          stage_idx_d  = cur_idx;
          stage_live_d = valid_q[cur_idx];
          cnt_d        = cnt_q + CntW'(1);
        end else begin
          state_d = spq_pkg::ST_DEL_PICK;
        end
        // strict less-than keeps the lowest index on a tie
        if (stage_q && stage_live_q && (!found_q || rd_prio < best_prio_q)) begin
          found_d     = 1'b1;
          best_idx_d  = stage_idx_q;
          best_prio_d = rd_prio;
          best_val_d  = rd_val;
        end
      end

      spq_pkg::ST_DEL_PICK: begin
        if (found_q) begin
          valid_d[best_idx_q] = 1'b0;
          res_status_d        = spq_pkg::STATUS_DONE;
          res_value_d         = best_val_ext[31:0];
          res_slot_d          = best_idx_q;
        end else begin
          res_status_d = spq_pkg::STATUS_EMPTY;
          res_value_d  = '0;
          res_slot_d   = '0;
        end
        state_d = spq_pkg::ST_FINISH;
      end

      spq_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_slot_d   = res_slot_ext[2:0];
          state_d      = spq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      stage_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      stage_q     <= stage_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_word_q   <= ins_word_d;
    stage_live_q <= stage_live_d;
    stage_idx_q  <= stage_idx_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_val_q   <= best_val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_slot_q   <= out_slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;
  assign out_slot_o  = out_slot_q;

endmodule

`default_nettype wire

// ===== rtl/core/spq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// spq_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_slot_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
